// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

// Same, but also checked while reset is applied.
`define ASSERT_NEXT_RAW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

// Expression must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant failed");

`endif

// ===== rtl/evc_pkg.sv =====
// Package for the velocity clamp step: widths, command codes, saturation helpers
// and the microcode sequence. No dependencies.
`default_nettype none
package evc_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 66;
  localparam int PC_W   = 7;

  localparam logic [2:0] CFG_DRAG     = 3'd0;
  localparam logic [2:0] CFG_MAX_SPD  = 3'd1;
  localparam logic [2:0] CFG_MAX_GRAV = 3'd2;
  localparam logic [2:0] CFG_GRAV_X   = 3'd3;
  localparam logic [2:0] CFG_GRAV_Y   = 3'd4;
  localparam logic [2:0] CFG_GRAV_Z   = 3'd5;

  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_DRAG   = 5'd1;
  localparam logic [4:0] OP_ACCSUB = 5'd2;
  localparam logic [4:0] OP_SCALE  = 5'd3;
  localparam logic [4:0] OP_MVADD  = 5'd4;
  localparam logic [4:0] OP_GMUL   = 5'd5;
  localparam logic [4:0] OP_GVADD  = 5'd6;
  localparam logic [4:0] OP_SUM    = 5'd7;
  localparam logic [4:0] OP_PMUL   = 5'd8;
  localparam logic [4:0] OP_PADD   = 5'd9;
  localparam logic [4:0] OP_L2CLR  = 5'd10;
  localparam logic [4:0] OP_SQ     = 5'd11;
  localparam logic [4:0] OP_L2ACC  = 5'd12;
  localparam logic [4:0] OP_CAPSQ  = 5'd13;
  localparam logic [4:0] OP_CMP    = 5'd14;
  localparam logic [4:0] OP_SQRT   = 5'd15;
  localparam logic [4:0] OP_MC     = 5'd16;
  localparam logic [4:0] OP_DIV    = 5'd17;
  localparam logic [4:0] OP_WRQ    = 5'd18;

  localparam logic [PC_W-1:0] PC_CLAMP_M = 7'd12;
  localparam logic [PC_W-1:0] PC_GRAV    = 7'd31;
  localparam logic [PC_W-1:0] PC_CLAMP_G = 7'd37;
  localparam logic [PC_W-1:0] PC_SUM     = 7'd56;
  localparam logic [PC_W-1:0] PC_POS     = 7'd59;
  localparam logic [PC_W-1:0] PC_LAST    = 7'd64;

  typedef struct packed {
    logic [4:0]      op;
    logic [1:0]      idx;
    logic            vsel;
    logic [PC_W-1:0] jmp;
  } uop_t;

  typedef struct packed {
    logic exec;
    uop_t uop;
    logic load_in;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W:0] s);
    logic signed [DATA_W-1:0] r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_sat(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-1:0] sh;
    logic signed [DATA_W-1:0] r;
    sh = p[PROD_W-1:FRAC_W];
    if ((&sh[PROD_W-FRAC_W-1:DATA_W-1]) || !(|sh[PROD_W-FRAC_W-1:DATA_W-1])) begin
      r = sh[DATA_W-1:0];
    end else begin
      r = sh[PROD_W-FRAC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic uop_t clamp_uop(input logic [4:0] off, input logic vsel,
                                     input logic [PC_W-1:0] skip);
    uop_t u;
    u.op = OP_NOP;
    u.idx = 2'd0;
    u.vsel = vsel;
    u.jmp = skip;
    case (off)
      5'd0:  u.op = OP_L2CLR;
      5'd1:  begin u.op = OP_SQ; u.idx = 2'd0; end
      5'd2:  u.op = OP_L2ACC;
      5'd3:  begin u.op = OP_SQ; u.idx = 2'd1; end
      5'd4:  u.op = OP_L2ACC;
      5'd5:  begin u.op = OP_SQ; u.idx = 2'd2; end
      5'd6:  u.op = OP_L2ACC;
      5'd7:  u.op = OP_CAPSQ;
      5'd8:  u.op = OP_CMP;
      5'd9:  u.op = OP_SQRT;
      5'd10: begin u.op = OP_MC; u.idx = 2'd0; end
      5'd11: u.op = OP_DIV;
      5'd12: begin u.op = OP_WRQ; u.idx = 2'd0; end
      5'd13: begin u.op = OP_MC; u.idx = 2'd1; end
      5'd14: u.op = OP_DIV;
      5'd15: begin u.op = OP_WRQ; u.idx = 2'd1; end
      5'd16: begin u.op = OP_MC; u.idx = 2'd2; end
      5'd17: u.op = OP_DIV;
      5'd18: begin u.op = OP_WRQ; u.idx = 2'd2; end
      default: u.op = OP_NOP;
    endcase
    return u;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    logic [PC_W-1:0] off;
    u.op = OP_NOP;
    u.idx = 2'd0;
    u.vsel = 1'b0;
    u.jmp = '0;
    off = '0;
    if (pc < PC_CLAMP_M) begin
      u.idx = pc[3:2];
      case (pc[1:0])
        2'd0: u.op = OP_DRAG;
        2'd1: u.op = OP_ACCSUB;
        2'd2: u.op = OP_SCALE;
        default: u.op = OP_MVADD;
      endcase
    end else if (pc < PC_GRAV) begin
      off = pc - PC_CLAMP_M;
      u = clamp_uop(off[4:0], 1'b0, PC_GRAV);
    end else if (pc < PC_CLAMP_G) begin
      off = pc - PC_GRAV;
      u.idx = off[2:1];
      u.op = off[0] ? OP_GVADD : OP_GMUL;
    end else if (pc < PC_SUM) begin
      off = pc - PC_CLAMP_G;
      u = clamp_uop(off[4:0], 1'b1, PC_SUM);
    end else if (pc < PC_POS) begin
      off = pc - PC_SUM;
      u.idx = off[1:0];
      u.op = OP_SUM;
    end else begin
      off = pc - PC_POS;
      u.idx = off[2:1];
      u.op = off[0] ? OP_PADD : OP_PMUL;
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/evc_sqrt.sv =====
// Iterative integer square root of a 64-bit radicand, two bits per cycle.
// Depends on evc_pkg.
`default_nettype none
module evc_sqrt import evc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy_r;
  logic        done_r;
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
`default_nettype wire

// ===== rtl/evc_div.sv =====
// Restoring divider, 62-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on evc_pkg.
`default_nettype none
module evc_div import evc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [61:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  localparam logic [5:0] LAST_STEP = 6'd61;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [61:0] dvd_r;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r, dvd_r[61]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= 6'(cnt_r + 6'd1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      dvd_r <= {dvd_r[60:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r[31:0];

endmodule
`default_nettype wire

// ===== rtl/evc_dp.sv =====
// Datapath: configuration, motion state, shared multiplier, square root and divider.
// Depends on evc_pkg, evc_sqrt and evc_div.
`default_nettype none
module evc_dp import evc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [31:0]              cfg_data,
  input  wire logic [30:0]              in_frame_time,
  input  wire logic signed [DATA_W-1:0] in_accel_x,
  input  wire logic signed [DATA_W-1:0] in_accel_y,
  input  wire logic signed [DATA_W-1:0] in_accel_z,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_position_x,
  output logic signed [DATA_W-1:0]      out_position_y,
  output logic signed [DATA_W-1:0]      out_position_z,
  output logic signed [DATA_W-1:0]      out_total_velocity_x,
  output logic signed [DATA_W-1:0]      out_total_velocity_y,
  output logic signed [DATA_W-1:0]      out_total_velocity_z
);

  logic [30:0]              drag_r;
  logic [30:0]              max_spd_r;
  logic [30:0]              max_grav_r;
  logic signed [DATA_W-1:0] grav_r [3];

  logic signed [DATA_W-1:0] mv_r [3];
  logic signed [DATA_W-1:0] gv_r [3];
  logic signed [DATA_W-1:0] pos_r [3];
  logic signed [DATA_W-1:0] sv_r [3];
  logic signed [DATA_W-1:0] acc_r [3];
  logic [30:0]              dt_r;
  logic signed [DATA_W-1:0] tmp_r;
  logic [63:0]              prod_r;
  logic [63:0]              l2_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] opos_r [3];
  logic signed [DATA_W-1:0] osv_r [3];

  logic [4:0]               op;
  logic [1:0]               idx;
  logic signed [DATA_W-1:0] cur;
  logic [31:0]              mag;
  logic [30:0]              cap;
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W:0]   sum;
  logic [31:0]              root;
  logic [31:0]              quot;
  logic                     sqrt_done;
  logic                     div_done;
  logic                     out_take;

  assign op  = cmd.exec ? cmd.uop.op : OP_NOP;
  assign idx = cmd.uop.idx;

  always_comb begin
    cur = cmd.uop.vsel ? gv_r[idx] : mv_r[idx];
    mag = cur[DATA_W-1] ? 32'(32'd0 - cur) : cur;
    cap = cmd.uop.vsel ? max_grav_r : max_spd_r;
    mul_a = '0;
    mul_b = '0;
    sum   = '0;
    case (op)
      OP_DRAG:  begin mul_a = {2'b00, drag_r}; mul_b = {mv_r[idx][31], mv_r[idx]}; end
      OP_SCALE: begin mul_a = {2'b00, dt_r}; mul_b = {tmp_r[31], tmp_r}; end
      OP_GMUL:  begin mul_a = {2'b00, dt_r}; mul_b = {grav_r[idx][31], grav_r[idx]}; end
      OP_PMUL:  begin mul_a = {2'b00, dt_r}; mul_b = {sv_r[idx][31], sv_r[idx]}; end
      OP_SQ:    begin mul_a = {1'b0, mag}; mul_b = {1'b0, mag}; end
      OP_CAPSQ: begin mul_a = {2'b00, cap}; mul_b = {2'b00, cap}; end
      OP_MC:    begin mul_a = {1'b0, mag}; mul_b = {2'b00, cap}; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    case (op)
      OP_ACCSUB: sum = {acc_r[idx][31], acc_r[idx]} - {tmp_r[31], tmp_r};
      OP_MVADD:  sum = {mv_r[idx][31], mv_r[idx]} + {tmp_r[31], tmp_r};
      OP_GVADD:  sum = {gv_r[idx][31], gv_r[idx]} + {tmp_r[31], tmp_r};
      OP_SUM:    sum = {mv_r[idx][31], mv_r[idx]} + {gv_r[idx][31], gv_r[idx]};
      OP_PADD:   sum = {pos_r[idx][31], pos_r[idx]} + {tmp_r[31], tmp_r};
      default:   sum = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  evc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_SQRT),
    .radicand (l2_r),
    .done     (sqrt_done),
    .root     (root)
  );

  evc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_DIV),
    .dividend (prod_r[61:0]),
    .divisor  ((root == 32'd0) ? 32'd1 : root),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r     <= '0;
      max_spd_r  <= '1;
      max_grav_r <= '1;
      grav_r[0]  <= '0;
      grav_r[1]  <= -32'sd65536;
      grav_r[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRAG:     drag_r     <= cfg_data[30:0];
        CFG_MAX_SPD:  max_spd_r  <= cfg_data[30:0];
        CFG_MAX_GRAV: max_grav_r <= cfg_data[30:0];
        CFG_GRAV_X:   grav_r[0]  <= cfg_data;
        CFG_GRAV_Y:   grav_r[1]  <= cfg_data;
        CFG_GRAV_Z:   grav_r[2]  <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mv_r[i]  <= '0;
        gv_r[i]  <= '0;
        pos_r[i] <= '0;
        sv_r[i]  <= '0;
      end
    end else begin
      case (op)
        OP_MVADD: mv_r[idx]  <= sat_add(sum);
        OP_GVADD: gv_r[idx]  <= sat_add(sum);
        OP_SUM:   sv_r[idx]  <= sat_add(sum);
        OP_PADD:  pos_r[idx] <= sat_add(sum);
        OP_WRQ: begin
          if (cmd.uop.vsel) begin
            gv_r[idx] <= cur[DATA_W-1] ? 32'(32'd0 - quot) : quot;
          end else begin
            mv_r[idx] <= cur[DATA_W-1] ? 32'(32'd0 - quot) : quot;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r     <= in_frame_time;
      acc_r[0] <= in_accel_x;
      acc_r[1] <= in_accel_y;
      acc_r[2] <= in_accel_z;
    end
    case (op)
      OP_DRAG, OP_SCALE, OP_GMUL, OP_PMUL: tmp_r <= fx_sat(prod);
      OP_ACCSUB: tmp_r <= sat_add(sum);
      OP_GVADD:  ;
      default:   ;
    endcase
    case (op)
      OP_SQ, OP_CAPSQ, OP_MC: prod_r <= prod[63:0];
      default: ;
    endcase
    case (op)
      OP_L2CLR: l2_r <= '0;
      OP_L2ACC: l2_r <= l2_r + prod_r;
      default:  ;
    endcase
    if (cmd.load_out) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= pos_r[i];
        osv_r[i]  <= sv_r[i];
      end
    end
  end

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.over      = l2_r > prod_r;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid            = out_valid_r;
  assign out_position_x       = opos_r[0];
  assign out_position_y       = opos_r[1];
  assign out_position_z       = opos_r[2];
  assign out_total_velocity_x = osv_r[0];
  assign out_total_velocity_y = osv_r[1];
  assign out_total_velocity_z = osv_r[2];

endmodule
`default_nettype wire

// ===== rtl/evc_ctrl.sv =====
// Controller: steps through the microcode sequence, waits on the iterative units and waits for the output to be free.
// Depends on evc_pkg.
`default_nettype none
module evc_ctrl import evc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_motion_enable,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WSQ  = 3'd2;
  localparam logic [2:0] S_WDIV = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            uop;

  assign uop = ucode(pc_r);

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    cmd.exec     = 1'b0;
    cmd.uop      = uop;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = in_motion_enable ? S_EXEC : S_FIN;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (uop.op == OP_SQRT) begin
          state_nxt = S_WSQ;
        end else if (uop.op == OP_DIV) begin
          state_nxt = S_WDIV;
        end else if (uop.op == OP_CMP && !stat.over) begin
          pc_nxt = uop.jmp;
        end else if (pc_r == PC_LAST) begin
          state_nxt = S_FIN;
        end else begin
          pc_nxt = PC_W'(pc_r + 1'b1);
        end
      end
      S_WSQ: begin
        if (stat.sqrt_done) begin
          pc_nxt    = PC_W'(pc_r + 1'b1);
          state_nxt = S_EXEC;
        end
      end
      S_WDIV: begin
        if (stat.div_done) begin
          pc_nxt    = PC_W'(pc_r + 1'b1);
          state_nxt = S_EXEC;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/euler_velocity_clamp_step.sv =====
// A disabled transaction goes from acceptance to the final state, which loads its result
// once the output is free. An enabled one runs 45 microcode steps when neither speed
// clamp triggers; each clamp that triggers adds 10 steps, a square root wait and three
// division waits. One transaction at a time: the next can be accepted in the cycle after
// the result is loaded. Synchronous active-low reset clears velocities and position and
// resets the configuration registers.
`default_nettype none
module euler_velocity_clamp_step import evc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [30:0]              in_frame_time,
  input  wire logic signed [DATA_W-1:0] in_accel_x,
  input  wire logic signed [DATA_W-1:0] in_accel_y,
  input  wire logic signed [DATA_W-1:0] in_accel_z,
  input  wire logic                     in_motion_enable,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_position_x,
  output logic signed [DATA_W-1:0]      out_position_y,
  output logic signed [DATA_W-1:0]      out_position_z,
  output logic signed [DATA_W-1:0]      out_total_velocity_x,
  output logic signed [DATA_W-1:0]      out_total_velocity_y,
  output logic signed [DATA_W-1:0]      out_total_velocity_z,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [31:0]              cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  evc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_motion_enable (in_motion_enable),
    .in_stall         (in_stall),
    .stat             (stat),
    .cmd              (cmd)
  );

  evc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_frame_time        (in_frame_time),
    .in_accel_x           (in_accel_x),
    .in_accel_y           (in_accel_y),
    .in_accel_z           (in_accel_z),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_position_x       (out_position_x),
    .out_position_y       (out_position_y),
    .out_position_z       (out_position_z),
    .out_total_velocity_x (out_total_velocity_x),
    .out_total_velocity_y (out_total_velocity_y),
    .out_total_velocity_z (out_total_velocity_z)
  );

endmodule
`default_nettype wire

// ===== rtl/evc_checker.sv =====
// Port-level checker for the velocity clamp step, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module evc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  `ASSERT_NEXT_RAW(a_reset_clears_out, !rst_n, !out_valid)
  `ASSERT_NEXT_RAW(a_reset_ready, !rst_n, !in_stall)
  `ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ASSERT_ALWAYS(a_cfg_ready, cfg_ready || !cfg_valid)

endmodule

bind euler_velocity_clamp_step evc_checker u_chk (.*);
`default_nettype wire
